// ----- rtl/segx_pkg.sv -----
// segx_pkg: shared default coordinate width for the segment intersection block
// no dependencies

package segx_pkg;

   localparam int COORD_WIDTH_DEF = 16;

endpackage

// ----- rtl/segx_div_cell.sv -----
// segx_div_cell: one restoring-division step of the quotient chain
// depends on segx_pkg

module segx_div_cell import segx_pkg::*; #(
   parameter int DW = 4 * COORD_WIDTH_DEF + 2,
   parameter int CW = 2 * COORD_WIDTH_DEF + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          vld_i,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] quo_i,
   input  logic [CW-1:0] den_i,
   output logic          vld_o,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] quo_o,
   output logic [CW-1:0] den_o
);

   logic          vld_ff, vld_in;
   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in, shf;
   logic [CW-1:0] den_ff;
   logic [DW:0]   trial;

   // shift remainder one bit, try subtracting the divisor from the top
   always_comb begin
      shf    = {rem_i[DW-2:0], quo_i[DW-1]};
      trial  = {1'b0, shf} - ({1'b0, {(DW-CW){1'b0}}, den_i});
      vld_in = vld_i;
      if (!trial[DW]) begin
         rem_in = trial[DW-1:0];
         quo_in = {quo_i[DW-2:0], 1'b1};
      end else begin
         rem_in = shf;
         quo_in = {quo_i[DW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_i;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign quo_o  = quo_ff;
   assign den_o  = den_ff;

endmodule

// ----- rtl/segx_front.sv -----
// segx_front: differences, cross products, range test and offset products
// depends on segx_pkg

module segx_front import segx_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       vld_i,
   input  logic signed [CW-1:0]       x0, y0, x1, y1, x2, y2, x3, y3,
   output logic                       vld_o,
   output logic                       hit_o,
   output logic [4*CW+1:0]            mag_x_o,
   output logic [4*CW+1:0]            mag_y_o,
   output logic                       neg_x_o,
   output logic                       neg_y_o,
   output logic [2*CW+1:0]            den_o,
   output logic signed [CW-1:0]       x0_o,
   output logic signed [CW-1:0]       y0_o
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * CW + 3;
   localparam int MW = 4 * CW + 2;

   // stage 1: differences
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, dx_ff, dy_ff;
   logic signed [CW-1:0] s1x_ff, s1y_ff;
   logic                 s1v_ff;
   // stage 2: cross products
   logic signed [PW-1:0] den_ff, sn_ff, tn_ff;
   logic signed [DW-1:0] s2ax_ff, s2ay_ff;
   logic signed [CW-1:0] s2x_ff, s2y_ff;
   logic                 s2v_ff;
   // stage 3: normalize sign and range test
   logic signed [PW-1:0] den_in, sn_in, tn_in, dn3_ff, tn3_ff;
   logic                 hit_in, hit3_ff, s3v_ff;
   logic signed [DW-1:0] s3ax_ff, s3ay_ff;
   logic signed [CW-1:0] s3x_ff, s3y_ff;
   // stage 4: offset products
   logic signed [PW+DW-1:0] px_in, py_in;
   logic [MW-1:0]        mx_ff, my_ff;
   logic                 nx_ff, ny_ff, hit4_ff, s4v_ff;
   logic [PW-2:0]        dn4_ff;
   logic signed [CW-1:0] s4x_ff, s4y_ff;

   always_comb begin
      den_in = den_ff;
      sn_in  = sn_ff;
      tn_in  = tn_ff;
      if (den_ff < 0) begin
         den_in = -den_ff;
         sn_in  = -sn_ff;
         tn_in  = -tn_ff;
      end
      hit_in = (den_ff != '0) && (sn_in >= 0) && (sn_in <= den_in)
               && (tn_in >= 0) && (tn_in <= den_in);
      px_in = tn3_ff * s3ax_ff;
      py_in = tn3_ff * s3ay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff <= 1'b0;
         s2v_ff <= 1'b0;
         s3v_ff <= 1'b0;
         s4v_ff <= 1'b0;
      end else if (adv) begin
         s1v_ff <= vld_i;
         s2v_ff <= s1v_ff;
         s3v_ff <= s2v_ff;
         s4v_ff <= s3v_ff;
      end
      if (adv) begin
         ax_ff  <= DW'(x1) - DW'(x0);
         ay_ff  <= DW'(y1) - DW'(y0);
         bx_ff  <= DW'(x3) - DW'(x2);
         by_ff  <= DW'(y3) - DW'(y2);
         dx_ff  <= DW'(x0) - DW'(x2);
         dy_ff  <= DW'(y0) - DW'(y2);
         s1x_ff <= x0;
         s1y_ff <= y0;
         den_ff <= PW'(ax_ff * by_ff) - PW'(bx_ff * ay_ff);
         sn_ff  <= PW'(ax_ff * dy_ff) - PW'(ay_ff * dx_ff);
         tn_ff  <= PW'(bx_ff * dy_ff) - PW'(by_ff * dx_ff);
         s2ax_ff <= ax_ff;
         s2ay_ff <= ay_ff;
         s2x_ff  <= s1x_ff;
         s2y_ff  <= s1y_ff;
         dn3_ff  <= den_in;
         tn3_ff  <= tn_in;
         hit3_ff <= hit_in;
         s3ax_ff <= s2ax_ff;
         s3ay_ff <= s2ay_ff;
         s3x_ff  <= s2x_ff;
         s3y_ff  <= s2y_ff;
         nx_ff   <= px_in < 0;
         ny_ff   <= py_in < 0;
         mx_ff   <= MW'(px_in < 0 ? -px_in : px_in);
         my_ff   <= MW'(py_in < 0 ? -py_in : py_in);
         dn4_ff  <= hit3_ff ? dn3_ff[PW-2:0] : {{(PW-2){1'b0}}, 1'b1};
         hit4_ff <= hit3_ff;
         s4x_ff  <= s3x_ff;
         s4y_ff  <= s3y_ff;
      end
   end

   assign vld_o   = s4v_ff;
   assign hit_o   = hit4_ff;
   assign mag_x_o = mx_ff;
   assign mag_y_o = my_ff;
   assign neg_x_o = nx_ff;
   assign neg_y_o = ny_ff;
   assign den_o   = dn4_ff;
   assign x0_o    = s4x_ff;
   assign y0_o    = s4y_ff;

endmodule

// ----- rtl/segment_intersection.sv -----
// segment_intersection: top level, cross-product front end and two chains of division cells
// depends on segx_pkg, segx_front, segx_div_cell
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, 8 coordinates
//  rsp     | out       | rsp_valid, rsp_stall, rsp_hit, rsp_cross_x, rsp_cross_y
//
// one request per cycle unless a held result is stalled; the division chain has one
// cell per quotient bit
// reset clears every valid bit; no clearing pass
// the whole pipe advances when the output register is empty or being taken

module segment_intersection import segx_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);

   localparam int CW = COORD_WIDTH;
   localparam int MW = 4 * CW + 2;
   localparam int DNW = 2 * CW + 2;
   localparam int NC = MW;

   logic adv;
   logic fv, fhit, fnx, fny;
   logic [MW-1:0] fmx, fmy;
   logic [DNW-1:0] fden;
   logic signed [CW-1:0] fx0, fy0;

   // side data carried along the chain: hit, signs, start point
   localparam int SW = 2 * CW + 3;
   logic [SW-1:0] fside;

   logic [NC:0]          cv;
   logic [MW-1:0]        rx [0:NC];
   logic [MW-1:0]        qx [0:NC];
   logic [MW-1:0]        ry [0:NC];
   logic [MW-1:0]        qy [0:NC];
   logic [DNW-1:0]       dx [0:NC];
   logic [DNW-1:0]       dy [0:NC];
   logic [SW-1:0]        sx [0:NC];
   logic [NC:0]          cvy;

   logic                 ov_ff;
   logic                 oh_ff;
   logic signed [CW-1:0] ox_ff, oy_ff;
   logic [MW-1:0]        offx, offy;
   logic [SW-1:0]        sd;

   assign adv       = !ov_ff || !rsp_stall;
   assign req_stall = !adv;

   segx_front #(.CW(CW)) u_front (
      .clock, .reset, .adv, .vld_i(req_valid),
      .x0(req_a_start_x), .y0(req_a_start_y), .x1(req_a_end_x), .y1(req_a_end_y),
      .x2(req_b_start_x), .y2(req_b_start_y), .x3(req_b_end_x), .y3(req_b_end_y),
      .vld_o(fv), .hit_o(fhit), .mag_x_o(fmx), .mag_y_o(fmy), .neg_x_o(fnx),
      .neg_y_o(fny), .den_o(fden), .x0_o(fx0), .y0_o(fy0)
   );

   assign fside = {fhit, fnx, fny, fx0, fy0};
   assign cv[0] = fv;
   assign cvy[0] = fv;
   assign rx[0] = '0;
   assign qx[0] = fmx;
   assign ry[0] = '0;
   assign qy[0] = fmy;
   assign dx[0] = fden;
   assign dy[0] = fden;
   assign sx[0] = fside;

   // two parallel chains, one quotient bit per cell
   for (genvar i = 0; i < NC; i++) begin : g_cell
      segx_div_cell #(.DW(MW), .CW(DNW)) u_cx (
         .clock, .reset, .adv, .vld_i(cv[i]), .rem_i(rx[i]), .quo_i(qx[i]),
         .den_i(dx[i]), .vld_o(cv[i+1]), .rem_o(rx[i+1]),
         .quo_o(qx[i+1]), .den_o(dx[i+1])
      );
      segx_div_cell #(.DW(MW), .CW(DNW)) u_cy (
         .clock, .reset, .adv, .vld_i(cvy[i]), .rem_i(ry[i]), .quo_i(qy[i]),
         .den_i(dy[i]), .vld_o(cvy[i+1]), .rem_o(ry[i+1]),
         .quo_o(qy[i+1]), .den_o(dy[i+1])
      );
      // side data rides beside the cells, one register per step
      logic [SW-1:0] side_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff <= sx[i];
         end
      end
      assign sx[i+1] = side_ff;
   end

   // output register: apply sign, add start point, zero coordinates on a miss
   assign sd   = sx[NC];
   assign offx = sd[2*CW+1] ? -qx[NC] : qx[NC];
   assign offy = sd[2*CW]   ? -qy[NC] : qy[NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= cv[NC];
      end
      if (adv) begin
         oh_ff <= sd[2*CW+2];
         ox_ff <= sd[2*CW+2] ? sd[2*CW-1:CW] + CW'(offx) : '0;
         oy_ff <= sd[2*CW+2] ? sd[CW-1:0] + CW'(offy) : '0;
      end
   end

   assign rsp_valid   = ov_ff;
   assign rsp_hit     = oh_ff;
   assign rsp_cross_x = ox_ff;
   assign rsp_cross_y = oy_ff;

   // both chains carry the same requests
   a_chain_sync: assert property (@(posedge clock) disable iff (reset) cv == cvy)
      else $error("division chains out of step");
   // no result without a hit has nonzero coordinates
   a_zero_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("miss with nonzero coordinates");
   // a stalled result holds its valid, hit and x coordinate
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cross_x) && $stable(rsp_hit))
      else $error("stalled result changed");

endmodule
